FILE: rtl/plh_pkg.sv
// Shared types and constants for the packet length histogram.
package plh_pkg;

    localparam int unsigned TOP_BIN_W   = 11;
    localparam int unsigned VALUE_W     = 16;
    localparam int unsigned COUNT_W     = 64;
    // Compare width: holds a length and any bin index up to 65536 entries.
    localparam int unsigned CMP_W       = 17;

    localparam logic [TOP_BIN_W-1:0] TOP_BIN_RESET = 11'd1599;

    localparam logic MODE_COUNT = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef enum logic
    {
        ST_CLEAR,
        ST_RUN
    } plh_state_t;

endpackage

FILE: rtl/plh_ram.sv
// Generic simple dual-port RAM with registered read data.
module plh_ram
#(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 2048
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/packet_length_histogram.sv
// Packet length histogram: NUM_BINS 64-bit counters held in one synchronous RAM.
// In count mode (mode = 0) the length on value is clamped to the top bin and that
// bin's counter is incremented, wrapping at 2^64; the result carries the bin and
// its new count. In read mode (mode = 1) value names a bin, clamped the same way,
// and its count is returned untouched. batch_done echoes end_of_batch. The top
// bin comes from top_bin (reset 1599); a top_bin at or beyond NUM_BINS is
// treated as NUM_BINS-1. After reset the block sweeps the RAM to zero, one
// entry per cycle, over all NUM_BINS entries (2048 by default) with in_stall
// held high; top_bin may be written during the sweep. The RAM read issued at
// the input transfer returns in the next cycle; the counter is updated and
// written back as the result moves to the output register, and the next input
// transfer waits until the write has landed, so no forwarding path is needed.
// A finished result waits in the output register while the next input is taken.
module packet_length_histogram
#(
    parameter int unsigned NUM_BINS = 2048
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           top_bin_we,
    input  logic [plh_pkg::TOP_BIN_W-1:0]  top_bin_wdata,
    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           mode,
    input  logic [plh_pkg::VALUE_W-1:0]    value,
    input  logic                           end_of_batch,
    // output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [plh_pkg::TOP_BIN_W-1:0]  bin,
    output logic [plh_pkg::COUNT_W-1:0]    count,
    output logic                           batch_done
);

    import plh_pkg::*;

    localparam int unsigned AW = $clog2(NUM_BINS);
    localparam logic [CMP_W-1:0] LAST_BIN  = CMP_W'(NUM_BINS - 1);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(NUM_BINS - 1);

    plh_state_t state_reg, state_next;

    logic [TOP_BIN_W-1:0] top_bin_reg;
    logic [AW-1:0]        clr_ptr_reg, clr_ptr_next;

    // item in flight between RAM read and write-back
    logic                 pend_reg;
    logic                 pend_mode_reg;
    logic [AW-1:0]        pend_addr_reg;
    logic                 pend_eob_reg;

    // output register
    logic                 out_valid_reg;
    logic [TOP_BIN_W-1:0] bin_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic                 batch_done_reg;

    logic                 in_xfer;
    logic                 out_load;
    logic [CMP_W-1:0]     top_eff;
    logic [CMP_W-1:0]     value_ext;
    logic [CMP_W-1:0]     clamped;
    logic [CMP_W-1:0]     pend_bin_ext;
    logic [COUNT_W-1:0]   rd_count;
    logic [COUNT_W-1:0]   new_count;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [COUNT_W-1:0]   ram_wdata;

    // ---------------------------------------------------------------- clamp
    always_comb
    begin
        top_eff   = (CMP_W'(top_bin_reg) > LAST_BIN) ? LAST_BIN : CMP_W'(top_bin_reg);
        value_ext = CMP_W'(value);
        clamped   = (value_ext < top_eff) ? value_ext : top_eff;
    end

    assign in_xfer  = in_valid && !in_stall;
    // result moves to the output register once that register is free
    assign out_load = pend_reg && (!out_valid_reg || !out_stall);

    // ---------------------------------------------------------------- FSM
    always_comb
    begin
        state_next   = state_reg;
        clr_ptr_next = clr_ptr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_ptr_next = clr_ptr_reg + AW'(1);
                if (clr_ptr_reg == LAST_ADDR)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = new_count;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_ptr_reg;
                ram_wdata = '0;
            end
            ST_RUN:
            begin
                in_stall = pend_reg;
                ram_we   = out_load && (pend_mode_reg == MODE_COUNT);
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // ---------------------------------------------------------------- counters
    plh_ram
    #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_BINS)
    )
    u_bin_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_xfer),
        .raddr (clamped[AW-1:0]),
        .rdata (rd_count)
    );

    assign new_count    = (pend_mode_reg == MODE_COUNT) ? rd_count + COUNT_W'(1) : rd_count;
    assign pend_bin_ext = CMP_W'(pend_addr_reg);

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_ptr_reg   <= '0;
            top_bin_reg   <= TOP_BIN_RESET;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_ptr_reg <= clr_ptr_next;
            if (top_bin_we)
            begin
                top_bin_reg <= top_bin_wdata;
            end
            if (in_xfer)
            begin
                pend_reg <= 1'b1;
            end
            else if (out_load)
            begin
                pend_reg <= 1'b0;
            end
            out_valid_reg <= out_load || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pend_mode_reg <= mode;
            pend_addr_reg <= clamped[AW-1:0];
            pend_eob_reg  <= end_of_batch;
        end
        if (out_load)
        begin
            bin_reg        <= pend_bin_ext[TOP_BIN_W-1:0];
            count_reg      <= new_count;
            batch_done_reg <= pend_eob_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign bin        = bin_reg;
    assign count      = count_reg;
    assign batch_done = batch_done_reg;

    // ---------------------------------------------------------------- checks
    // no second transfer while a read-modify-write is open (interlock)
    a_interlock: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> in_stall)
        else $error("input taken while an item is in flight");

    // a transfer opens the in-flight slot
    a_pend_set: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> pend_reg)
        else $error("accepted item lost before write-back");

    // nothing moves during the clearing sweep
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!pend_reg && !out_valid_reg && in_stall))
        else $error("activity during RAM clear");

    // every count-mode result writes its counter back
    a_writeback: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (pend_mode_reg == MODE_COUNT)) |-> (ram_we && ram_waddr == pend_addr_reg))
        else $error("counter update not written back");

    // a read-mode result never touches the RAM
    a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN) && pend_reg && (pend_mode_reg == MODE_READ)) |-> !ram_we)
        else $error("read-mode item wrote the RAM");

endmodule
